### rtl/plb_pkg.sv
// shared types, constants and operation codes of the positional list buffer
package plb_pkg;

   // list geometry
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int LEN_W      = 7;
   localparam int OP_W       = 3;
   localparam int ST_W       = 2;
   localparam int FIELD_W    = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ   = 3'd0;
   localparam logic [OP_W-1:0] OP_MODIFY = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   // input transaction
   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [LEN_W-1:0]          position;
      logic signed [FIELD_W-1:0] value;
   } plb_req_type;

   // result transaction
   typedef struct packed {
      logic signed [FIELD_W-1:0] data;
      logic [ST_W-1:0]           status;
      logic [LEN_W-1:0]          length;
   } plb_rsp_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic                  wr;
      logic [IDX_W-1:0]      wr_idx;
      logic                  rd;
      logic                  shift_up;
      logic                  shift_down;
      logic [IDX_W-1:0]      base_idx;
      logic [DATA_WIDTH-1:0] wr_data;
   } plb_cmd_type;

endpackage

### rtl/positional_list_buffer.sv
// top level of the positional list buffer: controller, cell row, result register
//
// Ordered list of up to 64 signed 32-bit words with a current length.
// Input channel req_: one transaction carries operation, position and value
// (read, modify, insert, append, remove). Result channel rsp_: one transaction
// per input with data (read, old or removed word, else zero), status
// (ok, out of range, full) and the length after the operation.
// Timing: a transaction accepted at an edge has its result on rsp_ from the
// next cycle on, and the block takes one transaction per cycle while req_stall
// is low. Every entry sits in its own cell; inserts and removes move all
// later entries in the same cycle through neighbor links in the row, and
// reads pick the addressed cell through an OR of gated cell outputs.
// Reset clears the length and the result valid; entry contents are not
// cleared and are never visible, since only positions below the length are
// read. While rsp_stall holds a pending result, req_stall is high and the
// list does not change; the result stays on rsp_payload until taken.
module positional_list_buffer
   import plb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  plb_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output plb_rsp_type rsp_payload
);

   plb_cmd_type           cmd;
   logic                  accept;
   logic [ST_W-1:0]       status;
   logic [LEN_W-1:0]      length;
   logic [DATA_WIDTH-1:0] entry   [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_part [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_word;
   logic                  rsp_valid_ff;
   plb_rsp_type           rsp_ff;

   // handshake: hold input while a result waits on a stalled receiver
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   plb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cmd    (cmd),
      .status (status),
      .length (length)
   );

   // row of cells with neighbor links
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = entry[i+1];
      end
      plb_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_w),
         .right_data (right_w),
         .entry_out  (entry[i]),
         .read_out   (rd_part[i])
      );
   end

   // read word: at most one cell drives a nonzero value
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | rd_part[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.data   <= FIELD_W'(signed'(rd_word));
         rsp_ff.status <= status;
         rsp_ff.length <= length;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // length never exceeds the list capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.length <= LEN_W'(CAPACITY)))
      else $error("length beyond capacity");

   // an accepted transaction always leaves a pending result
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("result missing after accepted transaction");

   // full status only when the list is at capacity
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_FULL)) |->
      (rsp_ff.length == LEN_W'(CAPACITY)))
      else $error("full status with room left");

   // failed operations return zero data
   a_err_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_OK)) |-> (rsp_ff.data == '0))
      else $error("nonzero data on failed operation");

   // the list only changes on an accepted transaction
   a_no_cmd_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> (!cmd.wr && !cmd.shift_up && !cmd.shift_down))
      else $error("cell update without a transaction");

endmodule

### rtl/plb_cell.sv
// one list entry: holds a word and takes its neighbor's word on a shift
module plb_cell
   import plb_pkg::*;
(
   input  logic                  clock,
   input  logic [IDX_W-1:0]      cell_idx,
   input  plb_cmd_type           cmd,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] entry_out,
   output logic [DATA_WIDTH-1:0] read_out
);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   // next entry: direct write, shift up from left, shift down from right
   always_comb begin
      entry_in = entry_ff;
      if (cmd.wr && (cell_idx == cmd.wr_idx)) begin
         entry_in = cmd.wr_data;
      end else if (cmd.shift_up && (cell_idx > cmd.base_idx)) begin
         entry_in = left_data;
      end else if (cmd.shift_down && (cell_idx >= cmd.base_idx)) begin
         entry_in = right_data;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // read port gated by address match, ORed across the row
   assign read_out  = (cmd.rd && (cell_idx == cmd.base_idx)) ? entry_ff : '0;
   assign entry_out = entry_ff;

endmodule

### rtl/plb_ctrl.sv
// length register, range checks and command decode for the cell row
module plb_ctrl
   import plb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  plb_req_type       req,
   output plb_cmd_type       cmd,
   output logic [ST_W-1:0]   status,
   output logic [LEN_W-1:0]  length
);

   logic [LEN_W-1:0] count_ff;
   logic [LEN_W-1:0] count_in;
   logic             in_range;
   logic             ins_range;
   logic             full;
   plb_cmd_type      dec;

   // range and capacity checks against the current length
   assign in_range  = req.position < count_ff;
   assign ins_range = req.position <= count_ff;
   assign full      = count_ff == LEN_W'(CAPACITY);

   // operation decode
   always_comb begin
      dec            = '0;
      dec.base_idx   = req.position[IDX_W-1:0];
      dec.wr_idx     = req.position[IDX_W-1:0];
      dec.wr_data    = req.value[DATA_WIDTH-1:0];
      status         = ST_OK;
      count_in       = count_ff;
      unique case (req.operation)
         OP_READ: begin
            if (in_range) begin
               dec.rd = 1'b1;
            end else begin
               status = ST_RANGE;
            end
         end
         OP_MODIFY: begin
            if (in_range) begin
               dec.rd = 1'b1;
               dec.wr = 1'b1;
            end else begin
               status = ST_RANGE;
            end
         end
         OP_INSERT: begin
            if (!ins_range) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               dec.wr       = 1'b1;
               dec.shift_up = 1'b1;
               count_in     = count_ff + 1'b1;
            end
         end
         OP_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               dec.wr     = 1'b1;
               dec.wr_idx = count_ff[IDX_W-1:0];
               count_in   = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (in_range) begin
               dec.rd         = 1'b1;
               dec.shift_down = 1'b1;
               count_in       = count_ff - 1'b1;
            end else begin
               status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   // write and shift commands reach the cells only for an accepted transaction
   always_comb begin
      cmd            = dec;
      cmd.wr         = dec.wr && accept;
      cmd.shift_up   = dec.shift_up && accept;
      cmd.shift_down = dec.shift_down && accept;
   end

   // current length
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign length = count_in;

endmodule
